// ===== rtl/core/ocbe_pkg.sv =====
package ocbe_pkg;

   // Longest byte sequence of one request and the width of an index into it.
   localparam int BUF_LEN = 10;
   localparam int IDX_W   = $clog2(BUF_LEN);

   // Depth of the queue between the encoder and the serializer.
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [7:0] CTRL_BYTE       = 8'h80;
   localparam logic [7:0] NOP_BYTE        = 8'hE3;
   localparam logic [7:0] ACT_SCROLL      = 8'h2F;
   localparam logic [7:0] OP_DISP_OFF     = 8'hAE;
   localparam logic [7:0] OP_DISP_ON      = 8'hAF;
   localparam logic [7:0] OP_ADDR_MODE    = 8'h20;
   localparam logic [7:0] OP_COL_ADDR     = 8'h21;
   localparam logic [7:0] OP_PAGE_ADDR    = 8'h22;
   localparam logic [7:0] OP_START_LINE   = 8'h40;
   localparam logic [7:0] OP_DISP_OFFSET  = 8'hD3;
   localparam logic [7:0] OP_CLK_DIV      = 8'hD5;
   localparam logic [7:0] OP_CONTRAST     = 8'h81;
   localparam logic [7:0] OP_NORMAL       = 8'hA6;
   localparam logic [7:0] OP_INVERT       = 8'hA7;
   localparam logic [7:0] OP_RESUME_RAM   = 8'hA4;
   localparam logic [7:0] OP_ENTIRE_ON    = 8'hA5;
   localparam logic [7:0] OP_SEG_REMAP    = 8'hA0;
   localparam logic [7:0] OP_MUX_RATIO    = 8'hA8;
   localparam logic [7:0] OP_COM_NORMAL   = 8'hC0;
   localparam logic [7:0] OP_COM_INVERT   = 8'hC8;
   localparam logic [7:0] OP_COM_PINS     = 8'hDA;
   localparam logic [7:0] OP_PRECHARGE    = 8'hD9;
   localparam logic [7:0] OP_VCOMH        = 8'hDB;
   localparam logic [7:0] OP_CHARGE_PUMP  = 8'h8D;
   localparam logic [7:0] OP_SCROLL_OFF   = 8'h2E;
   localparam logic [7:0] OP_HSCROLL_L    = 8'h27;
   localparam logic [7:0] OP_HSCROLL_R    = 8'h26;
   localparam logic [7:0] OP_VHSCROLL_L   = 8'h2A;
   localparam logic [7:0] OP_VHSCROLL_R   = 8'h29;
   localparam logic [7:0] OP_VSCROLL_AREA = 8'hA3;

   typedef enum logic [4:0] {
      MODE_POWER_OFF     = 5'd0,
      MODE_POWER_ON      = 5'd1,
      MODE_ADDR_HORIZ    = 5'd2,
      MODE_ADDR_VERT     = 5'd3,
      MODE_ADDR_PAGE     = 5'd4,
      MODE_COL_ADDR      = 5'd5,
      MODE_PAGE_ADDR     = 5'd6,
      MODE_START_LINE    = 5'd7,
      MODE_DISP_OFFSET   = 5'd8,
      MODE_CLK_DIV       = 5'd9,
      MODE_CONTRAST      = 5'd10,
      MODE_NORMAL        = 5'd11,
      MODE_INVERT        = 5'd12,
      MODE_RESUME_RAM    = 5'd13,
      MODE_ENTIRE_ON     = 5'd14,
      MODE_SEG_REMAP     = 5'd15,
      MODE_MUX_RATIO     = 5'd16,
      MODE_COM_NORMAL    = 5'd17,
      MODE_COM_INVERT    = 5'd18,
      MODE_COM_PINS      = 5'd19,
      MODE_PRECHARGE     = 5'd20,
      MODE_VCOMH         = 5'd21,
      MODE_PUMP_ON       = 5'd22,
      MODE_PUMP_OFF      = 5'd23,
      MODE_SCROLL_OFF    = 5'd24,
      MODE_HSCROLL_L     = 5'd25,
      MODE_HSCROLL_R     = 5'd26,
      MODE_VHSCROLL_L    = 5'd27,
      MODE_VHSCROLL_R    = 5'd28,
      MODE_VSCROLL_AREA  = 5'd29
   } mode_type;

   // One encoded request: the byte sequence, the index of its final byte and
   // the error flag.
   typedef struct packed {
      logic [BUF_LEN-1:0][7:0] bytes;
      logic [IDX_W-1:0]        last_idx;
      logic                    error;
   } entry_type;

endpackage

// ===== rtl/core/ocbe_front.sv =====
module ocbe_front (
   input  logic                 start,
   input  logic                 q_full,
   input  logic [4:0]           req_mode,
   input  logic                 req_data_present,
   input  logic [2:0]           req_data_count,
   input  logic [7:0]           req_arg0,
   input  logic [7:0]           req_arg1,
   input  logic [7:0]           req_arg2,
   input  logic [7:0]           req_arg3,
   output logic                 push,
   output ocbe_pkg::entry_type  entry
);

   logic       h0, h1, h2, h3;
   logic       err;
   logic [7:0] scr_start;
   logic [7:0] scr_step;
   logic [7:0] scr_end_raw;
   logic [7:0] scr_end;
   logic [7:0] scr_op;

   assign push = start && !q_full;

   // An argument is usable when the list is present and the count covers it;
   // counts above four still cover all four.
   assign h0  = req_data_present && (req_data_count > 3'd0);
   assign h1  = req_data_present && (req_data_count > 3'd1);
   assign h2  = req_data_present && (req_data_count > 3'd2);
   assign h3  = req_data_present && (req_data_count > 3'd3);
   assign err = req_data_present && (req_data_count == 3'd0);

   assign scr_start   = h0 ? {5'd0, req_arg0[2:0]} : 8'h00;
   assign scr_step    = h1 ? {5'd0, req_arg1[2:0]} : 8'h00;
   assign scr_end_raw = h2 ? {5'd0, req_arg2[2:0]} : 8'h07;
   assign scr_end     = (scr_end_raw < scr_start) ? scr_start : scr_end_raw;

   always_comb begin
      unique case (req_mode)
         ocbe_pkg::MODE_HSCROLL_L:  scr_op = ocbe_pkg::OP_HSCROLL_L;
         ocbe_pkg::MODE_HSCROLL_R:  scr_op = ocbe_pkg::OP_HSCROLL_R;
         ocbe_pkg::MODE_VHSCROLL_L: scr_op = ocbe_pkg::OP_VHSCROLL_L;
         default:                   scr_op = ocbe_pkg::OP_VHSCROLL_R;
      endcase
   end

   always_comb begin
      for (int i = 0; i < ocbe_pkg::BUF_LEN; i++) begin
         entry.bytes[i] = (i % 2 == 1) ? ocbe_pkg::NOP_BYTE : ocbe_pkg::CTRL_BYTE;
      end
      entry.last_idx = ocbe_pkg::IDX_W'(1);
      entry.error    = 1'b0;

      unique case (req_mode) inside
         ocbe_pkg::MODE_POWER_OFF: entry.bytes[1] = ocbe_pkg::OP_DISP_OFF;
         ocbe_pkg::MODE_POWER_ON:  entry.bytes[1] = ocbe_pkg::OP_DISP_ON;
         ocbe_pkg::MODE_ADDR_HORIZ, ocbe_pkg::MODE_ADDR_VERT,
         ocbe_pkg::MODE_ADDR_PAGE: begin
            entry.bytes[1] = ocbe_pkg::OP_ADDR_MODE;
            entry.bytes[3] = {6'd0, req_mode[1:0] - 2'd2};
            entry.last_idx = ocbe_pkg::IDX_W'(3);
         end
         ocbe_pkg::MODE_COL_ADDR: begin
            entry.bytes[1] = ocbe_pkg::OP_COL_ADDR;
            entry.bytes[3] = h1 ? (req_arg0 & 8'h7F) : 8'h00;
            entry.bytes[5] = h1 ? (req_arg1 & 8'h7F) : 8'h7F;
            entry.last_idx = ocbe_pkg::IDX_W'(5);
         end
         ocbe_pkg::MODE_PAGE_ADDR: begin
            entry.bytes[1] = ocbe_pkg::OP_PAGE_ADDR;
            entry.bytes[3] = h1 ? (req_arg0 & 8'h07) : 8'h00;
            entry.bytes[5] = h1 ? (req_arg1 & 8'h07) : 8'h07;
            entry.last_idx = ocbe_pkg::IDX_W'(5);
         end
         ocbe_pkg::MODE_START_LINE:
            entry.bytes[1] = ocbe_pkg::OP_START_LINE | (h0 ? (req_arg0 & 8'h3F) : 8'h00);
         ocbe_pkg::MODE_DISP_OFFSET: begin
            entry.bytes[1] = ocbe_pkg::OP_DISP_OFFSET;
            entry.bytes[3] = h0 ? (req_arg0 & 8'h3F) : 8'h00;
            entry.last_idx = ocbe_pkg::IDX_W'(3);
         end
         ocbe_pkg::MODE_CLK_DIV: begin
            entry.bytes[1] = ocbe_pkg::OP_CLK_DIV;
            entry.bytes[3] = h0 ? req_arg0 : 8'h80;
            entry.last_idx = ocbe_pkg::IDX_W'(3);
         end
         ocbe_pkg::MODE_CONTRAST: begin
            entry.bytes[1] = ocbe_pkg::OP_CONTRAST;
            entry.bytes[3] = h0 ? req_arg0 : 8'h7F;
            entry.last_idx = ocbe_pkg::IDX_W'(3);
         end
         ocbe_pkg::MODE_NORMAL:      entry.bytes[1] = ocbe_pkg::OP_NORMAL;
         ocbe_pkg::MODE_INVERT:      entry.bytes[1] = ocbe_pkg::OP_INVERT;
         ocbe_pkg::MODE_RESUME_RAM:  entry.bytes[1] = ocbe_pkg::OP_RESUME_RAM;
         ocbe_pkg::MODE_ENTIRE_ON:   entry.bytes[1] = ocbe_pkg::OP_ENTIRE_ON;
         ocbe_pkg::MODE_SEG_REMAP:
            entry.bytes[1] = ocbe_pkg::OP_SEG_REMAP | {7'd0, h0 & req_arg0[0]};
         ocbe_pkg::MODE_MUX_RATIO: begin
            entry.bytes[1] = ocbe_pkg::OP_MUX_RATIO;
            entry.bytes[3] = h0 ? req_arg0 : 8'hFF;
            entry.last_idx = ocbe_pkg::IDX_W'(3);
         end
         ocbe_pkg::MODE_COM_NORMAL:  entry.bytes[1] = ocbe_pkg::OP_COM_NORMAL;
         ocbe_pkg::MODE_COM_INVERT:  entry.bytes[1] = ocbe_pkg::OP_COM_INVERT;
         ocbe_pkg::MODE_COM_PINS: begin
            entry.bytes[1] = ocbe_pkg::OP_COM_PINS;
            entry.bytes[3] = h0 ? (req_arg0 & 8'h32) : 8'h02;
            entry.last_idx = ocbe_pkg::IDX_W'(3);
         end
         ocbe_pkg::MODE_PRECHARGE: begin
            entry.bytes[1] = ocbe_pkg::OP_PRECHARGE;
            entry.bytes[3] = h0 ? req_arg0 : 8'h22;
            entry.last_idx = ocbe_pkg::IDX_W'(3);
         end
         ocbe_pkg::MODE_VCOMH: begin
            entry.bytes[1] = ocbe_pkg::OP_VCOMH;
            entry.bytes[3] = h0 ? (req_arg0 & 8'h70) : 8'h30;
            entry.last_idx = ocbe_pkg::IDX_W'(3);
         end
         ocbe_pkg::MODE_PUMP_ON: begin
            entry.bytes[1] = ocbe_pkg::OP_CHARGE_PUMP;
            entry.bytes[3] = 8'h14;
            entry.last_idx = ocbe_pkg::IDX_W'(3);
         end
         ocbe_pkg::MODE_PUMP_OFF: begin
            entry.bytes[1] = ocbe_pkg::OP_CHARGE_PUMP;
            entry.bytes[3] = 8'h10;
            entry.last_idx = ocbe_pkg::IDX_W'(3);
         end
         ocbe_pkg::MODE_SCROLL_OFF:  entry.bytes[1] = ocbe_pkg::OP_SCROLL_OFF;
         ocbe_pkg::MODE_HSCROLL_L, ocbe_pkg::MODE_HSCROLL_R: begin
            // The scroll setups pack their bytes without control bytes between them.
            entry.bytes[1] = scr_op;
            entry.bytes[2] = scr_op;
            entry.bytes[3] = 8'h00;
            entry.bytes[4] = scr_start;
            entry.bytes[5] = scr_step;
            entry.bytes[6] = scr_end;
            entry.bytes[7] = 8'h00;
            entry.bytes[8] = 8'hFF;
            entry.bytes[9] = ocbe_pkg::ACT_SCROLL;
            entry.last_idx = ocbe_pkg::IDX_W'(9);
         end
         ocbe_pkg::MODE_VHSCROLL_L, ocbe_pkg::MODE_VHSCROLL_R: begin
            entry.bytes[1] = scr_op;
            entry.bytes[2] = scr_op;
            entry.bytes[3] = 8'h00;
            entry.bytes[4] = scr_start;
            entry.bytes[5] = scr_step;
            entry.bytes[6] = scr_end;
            entry.bytes[7] = h3 ? (req_arg3 & 8'h3F) : 8'h01;
            entry.bytes[8] = ocbe_pkg::ACT_SCROLL;
            entry.last_idx = ocbe_pkg::IDX_W'(8);
         end
         ocbe_pkg::MODE_VSCROLL_AREA: begin
            entry.bytes[1] = ocbe_pkg::OP_VSCROLL_AREA;
            entry.bytes[2] = ocbe_pkg::OP_VSCROLL_AREA;
            entry.bytes[3] = h0 ? (req_arg0 & 8'h3F) : 8'h00;
            entry.bytes[4] = h1 ? (req_arg1 & 8'h7F) : 8'h40;
            entry.bytes[5] = ocbe_pkg::ACT_SCROLL;
            entry.last_idx = ocbe_pkg::IDX_W'(5);
         end
         default: entry.bytes[1] = ocbe_pkg::NOP_BYTE;
      endcase

      // A present but empty argument list yields a single zero error byte.
      if (err) begin
         entry.bytes[0] = 8'h00;
         entry.last_idx = '0;
         entry.error    = 1'b1;
      end
   end

endmodule

// ===== rtl/core/ocbe_queue.sv =====
module ocbe_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ocbe_pkg::entry_type  push_entry,
   input  logic                 pop,
   output logic                 full,
   output logic                 not_empty,
   output ocbe_pkg::entry_type  head
);

   ocbe_pkg::entry_type                slot_ff [ocbe_pkg::QDEPTH];
   logic [ocbe_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [ocbe_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [ocbe_pkg::QCNT_W-1:0]        count_ff, count_in;

   assign full      = (count_ff == ocbe_pkg::QCNT_W'(ocbe_pkg::QDEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == ocbe_pkg::QPTR_W'(ocbe_pkg::QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == ocbe_pkg::QPTR_W'(ocbe_pkg::QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("request written into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("request taken from an empty queue");
`endif

endmodule

// ===== rtl/core/ocbe_back.sv =====
module ocbe_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_not_empty,
   input  ocbe_pkg::entry_type  q_head,
   output logic                 pop,
   output logic                 rsp_strobe,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_last,
   output logic                 rsp_error
);

   logic                        active_ff, active_in;
   ocbe_pkg::entry_type         cur_ff, cur_in;
   logic [ocbe_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic                        strobe_ff, strobe_in;
   logic [7:0]                  byte_ff, byte_in;
   logic                        last_ff, last_in;
   logic                        error_ff, error_in;
   logic                        at_last;

   assign at_last = (idx_ff == cur_ff.last_idx);

   always_comb begin
      byte_in = '0;
      for (int i = 0; i < ocbe_pkg::BUF_LEN; i++) begin
         if (idx_ff == ocbe_pkg::IDX_W'(i)) begin
            byte_in = cur_ff.bytes[i];
         end
      end
   end

   // On the final byte of a request the next one is loaded at once, so
   // consecutive requests leave the port without a gap.
   always_comb begin
      pop       = 1'b0;
      active_in = active_ff;
      cur_in    = cur_ff;
      idx_in    = idx_ff;
      strobe_in = 1'b0;
      last_in   = at_last;
      error_in  = cur_ff.error;
      if (active_ff) begin
         strobe_in = 1'b1;
         if (at_last) begin
            if (q_not_empty) begin
               pop    = 1'b1;
               cur_in = q_head;
               idx_in = '0;
            end else begin
               active_in = 1'b0;
            end
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end else if (q_not_empty) begin
         pop       = 1'b1;
         cur_in    = q_head;
         idx_in    = '0;
         active_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      idx_ff   <= idx_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      error_ff <= error_in;
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;
   assign rsp_error    = error_ff;

`ifndef SYNTHESIS
   a_error_is_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_error) |-> (rsp_last && rsp_out_byte == 8'h00))
      else $error("error result is not a single zero byte");

   a_no_gap_in_sequence: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=> rsp_strobe)
      else $error("gap inside a byte sequence");

   a_pop_only_between: assert property (@(posedge clock) disable iff (reset)
      pop |-> (!active_ff || at_last))
      else $error("new request loaded in the middle of a sequence");
`endif

endmodule

// ===== rtl/core/oled_cmd_byte_encoder_top.sv =====
// Display command byte encoder. A request (command code, argument-list flag,
// count and four argument bytes) is taken at a clock edge with start high and
// busy low, and comes out as its I2C command byte sequence, one byte per cycle
// on rsp_out_byte with rsp_strobe high and rsp_last on the final byte. A
// sequence is 2 to 10 bytes long; a request with an empty argument list gives
// one zero byte with rsp_error set. A request taken at a clock edge is
// written into the queue, then loaded into the serializer's current-request
// register, and its bytes are registered onto the outputs. The byte
// serializer sets the pace; a queued sequence follows the previous one
// without a gap. Requests wait in a two-entry queue, and busy is high while
// that queue is full. The receiver must take every byte on the cycle it is
// shown; there is no way to stall the output.
module oled_cmd_byte_encoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [4:0] req_mode,
   input  logic       req_data_present,
   input  logic [2:0] req_data_count,
   input  logic [7:0] req_arg0,
   input  logic [7:0] req_arg1,
   input  logic [7:0] req_arg2,
   input  logic [7:0] req_arg3,
   output logic       rsp_strobe,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   output logic       rsp_error
);

   logic                 push;
   logic                 pop;
   logic                 q_full;
   logic                 q_not_empty;
   ocbe_pkg::entry_type  push_entry;
   ocbe_pkg::entry_type  q_head;

   assign busy = q_full;

   ocbe_front u_front (
      .start            (start),
      .q_full           (q_full),
      .req_mode         (req_mode),
      .req_data_present (req_data_present),
      .req_data_count   (req_data_count),
      .req_arg0         (req_arg0),
      .req_arg1         (req_arg1),
      .req_arg2         (req_arg2),
      .req_arg3         (req_arg3),
      .push             (push),
      .entry            (push_entry)
   );

   ocbe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   ocbe_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_not_empty  (q_not_empty),
      .q_head       (q_head),
      .pop          (pop),
      .rsp_strobe   (rsp_strobe),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .rsp_error    (rsp_error)
   );

endmodule
